@@ rtl/ckt_pkg.sv @@
// Shared types and codes for the coordinate keyed table.
`default_nettype none
package ckt_pkg;

	localparam int COORD_BITS = 16;
	localparam int TYPE_BITS  = 3;
	localparam int INDEX_BITS = 6;
	localparam int COUNT_BITS = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_DUP     = 2'd1;
	localparam logic [1:0] STAT_MISSING = 2'd2;
	localparam logic [1:0] STAT_FULL    = 2'd3;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
		logic [TYPE_BITS-1:0]  area_type;
	} ckt_req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  found;
		logic [INDEX_BITS-1:0] match_index;
		logic [TYPE_BITS-1:0]  match_type;
		logic [COUNT_BITS-1:0] entry_count;
	} ckt_rsp_t;

	// one table entry as held in a cell
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [TYPE_BITS-1:0]  ty;
	} ckt_entry_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic occ;     // cell lies below the entry count
		logic cmp_en;  // capture compare result
		logic load;    // take the appended entry
		logic shift;   // take the right neighbor's entry
	} ckt_ctl_t;

endpackage
`default_nettype wire

@@ rtl/ckt_cell.sv @@
// One table cell: holds an entry, compares it to the probe key, shifts from its neighbor.
`default_nettype none
module ckt_cell import ckt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ckt_ctl_t   ctl,
	input  wire ckt_entry_t probe,
	input  wire ckt_entry_t fill,
	input  wire ckt_entry_t nbr,
	output ckt_entry_t      entry,
	output logic            match
);

	ckt_entry_t entry_q;
	logic       match_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= fill;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= ctl.occ && (probe.x == entry_q.x) && (probe.y == entry_q.y);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule
`default_nettype wire

@@ rtl/coordinate_keyed_table.sv @@
// Coordinate keyed table: top level with sequencer, match reduction and response register.
// Each request has an accept step and an action step: at acceptance all cells compare the
// key against their entry in parallel and register the result; in the action step the match
// is reduced, the cells shift down (remove) or one cell loads the new entry (insert), and the
// response is registered. A new request is taken the cycle after that, while the previous
// response may still wait on rsp_stall; the action step holds while the response register is
// full and stalled. Entries are undefined after reset; count, state and valid flags clear.
`default_nettype none
module coordinate_keyed_table import ckt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire ckt_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_stall,
	output ckt_rsp_t      rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_ACT  = 1'b1;

	logic       state_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0] cmd_q;
	ckt_entry_t fill_q;
	logic       rsp_valid_q;
	ckt_rsp_t   rsp_q;

	logic accept;
	logic act_go;
	ckt_entry_t probe;

	ckt_entry_t entries [CAPACITY];
	ckt_ctl_t   ctl     [CAPACITY];
	logic [CAPACITY-1:0] match;

	logic             hit;
	logic [IDX_W-1:0] pos;
	logic [TYPE_BITS-1:0] mtype;
	logic             full;
	logic             insert_go;
	logic             remove_go;
	logic [1:0]       status;
	logic [CNT_W-1:0] count_next;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q == ST_ACT);
	assign act_go    = (state_q == ST_ACT) && !(rsp_valid_q && rsp_stall);

	assign probe.x  = req.coord_x;
	assign probe.y  = req.coord_y;
	assign probe.ty = req.area_type;

	// keys are unique in the table, so an OR over the cells gives the one match
	always_comb begin
		hit   = 1'b0;
		pos   = '0;
		mtype = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit   = hit | match[i];
			pos   = pos | ({IDX_W{match[i]}} & IDX_W'(i));
			mtype = mtype | ({TYPE_BITS{match[i]}} & entries[i].ty);
		end
	end

	assign full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		insert_go  = 1'b0;
		remove_go  = 1'b0;
		count_next = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				if (hit) begin
					status = STAT_DUP;
				end else if (full) begin
					status = STAT_FULL;
				end else begin
					status     = STAT_OK;
					insert_go  = act_go;
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_REMOVE: begin
				if (hit) begin
					status     = STAT_OK;
					remove_go  = act_go;
					count_next = count_q - CNT_W'(1);
				end else begin
					status = STAT_MISSING;
				end
			end
			default: begin
				status = hit ? STAT_OK : STAT_MISSING;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ckt_entry_t nbr;

		if (i == CAPACITY - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = entries[i+1];
		end

		assign ctl[i].occ    = (CNT_W'(i) < count_q);
		assign ctl[i].cmp_en = accept;
		assign ctl[i].load   = insert_go && (count_q == CNT_W'(i));
		assign ctl[i].shift  = remove_go && (IDX_W'(i) >= pos);

		ckt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[i]),
			.probe  (probe),
			.fill   (fill_q),
			.nbr    (nbr),
			.entry  (entries[i]),
			.match  (match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (act_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (act_go) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= req.cmd;
			fill_q.x  <= req.coord_x;
			fill_q.y  <= req.coord_y;
			fill_q.ty <= req.area_type;
		end
		if (act_go) begin
			rsp_q.status      <= status;
			rsp_q.found       <= hit;
			rsp_q.match_index <= INDEX_BITS'(pos);
			rsp_q.match_type  <= mtype;
			rsp_q.entry_count <= COUNT_BITS'(count_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACT) |-> $onehot0(match))
		else $error("more than one cell matched the key");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_rsp_after_act: assert property (@(posedge clk) disable iff (!arst_n)
		act_go |=> (rsp_valid && (state_q == ST_IDLE)))
		else $error("action cycle did not produce a response");

	a_count_moves_on_act: assert property (@(posedge clk) disable iff (!arst_n)
		!act_go |=> $stable(count_q))
		else $error("entry count changed outside an action cycle");

endmodule
`default_nettype wire

@@ bench/coordinate_keyed_table_test.sv @@
// Self-checking testbench for the coordinate keyed table.
`timescale 1ns / 1ps
module coordinate_keyed_table_test;
	import ckt_pkg::*;

	localparam int          TABLE_DEPTH  = 64;
	localparam int          POOL_SIZE    = 72;
	localparam int          PHASE_ITEMS  = 225;
	localparam int          PHASE_COUNT  = 6;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          DRAIN_CYCLES = 8;
	localparam int          MAX_REPORTS  = 10;
	// spare opcode, the block treats it as a query
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ckt_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ckt_rsp_t rsp;

	coordinate_keyed_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #2 clk = ~clk;

	// shadow of the table contents
	ckt_entry_t entries [TABLE_DEPTH];
	int         entry_total = 0;

	ckt_req_t   req_queue [$];
	ckt_rsp_t   rsp_expected [$];
	logic [15:0] pool_x [POOL_SIZE];
	logic [15:0] pool_y [POOL_SIZE];
	int         fill_ptr = 0;

	int         n_total     = 0;
	int         n_accepted  = 0;
	int         n_err       = 0;
	int         idle_cycles = 0;
	logic       req_taken   = 1'b0;
	int         req_gap     = 0;
	int         req_calm    = 0;
	int         rsp_hold    = 0;
	int         rsp_calm    = 0;
	ckt_rsp_t   got;
	ckt_rsp_t   want;

	// Applies one request to the shadow table and returns the response it yields.
	function automatic ckt_rsp_t table_apply(input ckt_req_t r);
		ckt_rsp_t o;
		int       hit_at;
		hit_at = -1;
		for (int i = 0; i < entry_total; i++) begin
			if (entries[i].x == r.coord_x && entries[i].y == r.coord_y) begin
				hit_at = i;
				break;
			end
		end
		o = '0;
		if (hit_at >= 0) begin
			o.found       = 1'b1;
			o.match_index = hit_at[INDEX_BITS-1:0];
			o.match_type  = entries[hit_at].ty;
		end
		case (r.cmd)
			CMD_INSERT: begin
				if (hit_at >= 0)
					o.status = STAT_DUP;
				else if (entry_total >= TABLE_DEPTH)
					o.status = STAT_FULL;
				else begin
					entries[entry_total] = '{x: r.coord_x, y: r.coord_y, ty: r.area_type};
					entry_total++;
					o.status = STAT_OK;
				end
			end
			CMD_REMOVE: begin
				if (hit_at >= 0) begin
					for (int i = hit_at + 1; i < entry_total; i++)
						entries[i-1] = entries[i];
					entry_total--;
					o.status = STAT_OK;
				end else
					o.status = STAT_MISSING;
			end
			default: o.status = (hit_at >= 0) ? STAT_OK : STAT_MISSING;
		endcase
		o.entry_count = entry_total[COUNT_BITS-1:0];
		return o;
	endfunction

	function automatic ckt_req_t mk_req(input logic [1:0] c, input logic [15:0] x,
			input logic [15:0] y, input logic [2:0] t);
		ckt_req_t r;
		r.cmd       = c;
		r.coord_x   = x;
		r.coord_y   = y;
		r.area_type = t;
		return r;
	endfunction

	function automatic ckt_req_t make_random(input phase_t ph);
		ckt_req_t r;
		int       pick;
		int       k;
		pick = $urandom_range(0, 99);
		case (ph)
			PH_FILL:  r.cmd = pick < 88 ? CMD_INSERT : pick < 94 ? CMD_REMOVE :
			                  pick < 98 ? CMD_QUERY : CMD_UNUSED;
			PH_DRAIN: r.cmd = pick < 10 ? CMD_INSERT : pick < 80 ? CMD_REMOVE :
			                  pick < 98 ? CMD_QUERY : CMD_UNUSED;
			default:  r.cmd = pick < 40 ? CMD_INSERT : pick < 70 ? CMD_REMOVE :
			                  pick < 97 ? CMD_QUERY : CMD_UNUSED;
		endcase
		if ($urandom_range(0, 99) < 8) begin
			// stray key, almost never present
			r.coord_x = 16'($urandom_range(0, 65535));
			r.coord_y = 16'($urandom_range(0, 65535));
		end else begin
			// walk the pool on fill so the table really reaches capacity
			if (ph == PH_FILL && r.cmd == CMD_INSERT && $urandom_range(0, 9) < 7) begin
				k        = fill_ptr;
				fill_ptr = (fill_ptr + 1) % POOL_SIZE;
			end else
				k = $urandom_range(0, POOL_SIZE - 1);
			r.coord_x = pool_x[k];
			r.coord_y = pool_y[k];
		end
		r.area_type = 3'($urandom_range(0, 7));
		return r;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// request driver
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap   <= req_gap - 1;
			end else if (req_queue.size() > 0) begin
				req       <= req_queue.pop_front();
				req_valid <= 1'b1;
				req_gap   <= pick_gap(req_calm > 0);
				if (req_calm > 0)
					req_calm <= req_calm - 1;
				else if ($urandom_range(0, 15) == 0)
					req_calm <= $urandom_range(40, 100);
			end else
				req_valid <= 1'b0;
		end
	end

	// response back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_hold > 0) begin
				rsp_stall <= 1'b1;
				rsp_hold  <= rsp_hold - 1;
			end else begin
				rsp_stall <= 1'b0;
				if (rsp_calm > 0)
					rsp_calm <= rsp_calm - 1;
				else if ($urandom_range(0, 99) == 0)
					rsp_calm <= $urandom_range(50, 200);
				else if ($urandom_range(0, 3) == 0)
					rsp_hold <= pick_gap(1'b0);
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= req_valid && !req_stall;
			if (req_valid && !req_stall) begin
				rsp_expected.push_back(table_apply(req));
				n_accepted++;
			end
			if (rsp_valid && !rsp_stall) begin
				got = rsp;
				if (rsp_expected.size() == 0) begin
					n_err++;
					if (n_err <= MAX_REPORTS)
						$display("unexpected response: status=%0d found=%0d idx=%0d type=%0d count=%0d",
							got.status, got.found, got.match_index, got.match_type,
							got.entry_count);
				end else begin
					want = rsp_expected.pop_front();
					if (got.status !== want.status || got.found !== want.found ||
							got.match_index !== want.match_index ||
							got.match_type !== want.match_type ||
							got.entry_count !== want.entry_count) begin
						n_err++;
						if (n_err <= MAX_REPORTS)
							$display({"response mismatch: exp status=%0d found=%0d idx=%0d ",
								"type=%0d count=%0d, got status=%0d found=%0d idx=%0d ",
								"type=%0d count=%0d"},
								want.status, want.found, want.match_index, want.match_type,
								want.entry_count, got.status, got.found, got.match_index,
								got.match_type, got.entry_count);
					end
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		// key pool: extremes first, then random keys, some sharing one coordinate
		pool_x[0] = 16'h7FFF; pool_y[0] = 16'h8000;
		pool_x[1] = 16'h8000; pool_y[1] = 16'h7FFF;
		pool_x[2] = 16'h0000; pool_y[2] = 16'h0000;
		pool_x[3] = 16'hFFFF; pool_y[3] = 16'hFFFF;
		pool_x[4] = 16'h7FFF; pool_y[4] = 16'h7FFF;
		pool_x[5] = 16'h8000; pool_y[5] = 16'h8000;
		for (int i = 6; i < POOL_SIZE; i++) begin
			pool_x[i] = 16'($urandom_range(0, 65535));
			pool_y[i] = 16'($urandom_range(0, 65535));
			if (i % 6 == 1)
				pool_x[i] = pool_x[i-1];
			if (i % 6 == 3)
				pool_y[i] = pool_y[i-1];
		end

		// directed: empty table, extreme keys, duplicate, partial key match,
		// spare opcode, removes from middle, front and back, repeat remove
		req_queue.push_back(mk_req(CMD_QUERY,  16'h1234, 16'h5678, 3'd1));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'h1234, 16'h5678, 3'd6));
		req_queue.push_back(mk_req(CMD_INSERT, 16'h7FFF, 16'h8000, 3'd7));
		req_queue.push_back(mk_req(CMD_INSERT, 16'h8000, 16'h7FFF, 3'd0));
		req_queue.push_back(mk_req(CMD_INSERT, 16'h0000, 16'h0000, 3'd5));
		req_queue.push_back(mk_req(CMD_INSERT, 16'hFFFF, 16'hFFFF, 3'd3));
		req_queue.push_back(mk_req(CMD_INSERT, 16'h7FFF, 16'h8000, 3'd2));
		req_queue.push_back(mk_req(CMD_QUERY,  16'h8000, 16'h7FFF, 3'd4));
		req_queue.push_back(mk_req(CMD_UNUSED, 16'h0000, 16'h0000, 3'd7));
		req_queue.push_back(mk_req(CMD_QUERY,  16'h7FFF, 16'h7FFF, 3'd0));
		req_queue.push_back(mk_req(CMD_QUERY,  16'h8000, 16'h8000, 3'd0));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'h0000, 16'h0000, 3'd1));
		req_queue.push_back(mk_req(CMD_QUERY,  16'hFFFF, 16'hFFFF, 3'd2));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'h7FFF, 16'h8000, 3'd0));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 3'd0));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'hFFFF, 16'hFFFF, 3'd0));
		req_queue.push_back(mk_req(CMD_UNUSED, 16'h8000, 16'h7FFF, 3'd0));
		req_queue.push_back(mk_req(CMD_REMOVE, 16'h8000, 16'h7FFF, 3'd0));
		req_queue.push_back(mk_req(CMD_QUERY,  16'h8000, 16'h7FFF, 3'd0));

		for (int p = 0; p < PHASE_COUNT; p++)
			for (int i = 0; i < PHASE_ITEMS; i++)
				req_queue.push_back(make_random(phase_t'(p % 3)));
		n_total = req_queue.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted != n_total || rsp_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		n_err += rsp_expected.size();
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/ckt_pkg.sv
rtl/ckt_cell.sv
rtl/coordinate_keyed_table.sv
bench/coordinate_keyed_table_test.sv
